@@ rtl/core/vcso_pkg.sv @@
// vcso_pkg: widths, codes and types shared by the voxel column occlusion stage
// no dependencies
`timescale 1ns / 1ps

package vcso_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;

    localparam int ADDR_W    = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int ROW_W     = 9;
    localparam int SPAN_W    = 8;
    localparam int COL_W     = 9;
    localparam int TEX_W     = 8;
    localparam int SCALE_W   = 23;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;

    localparam int H_SHIFT   = 6;
    localparam int HOR_SHIFT = 16;
    localparam int ROW_LSB   = 22;
    localparam int DIFF_W    = CFG_W + 1;
    localparam int PROD_W    = DIFF_W + SCALE_W + 1;
    localparam int ACC_W     = PROD_W + 1;

    localparam logic signed [CFG_W-1:0] CAM_HEIGHT_RESET  = 17'sd0;
    localparam logic signed [CFG_W-1:0] HORIZON_ROW_RESET = 17'sd6400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAM_HEIGHT  = 1'b0,
        CFG_HORIZON_ROW = 1'b1
    } cfg_index_t;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_CLEAR  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_RUN,
        ST_DRAIN
    } occ_state_t;

    typedef struct packed {
        logic              span_valid;
        logic [COL_W-1:0]  column;
        logic [SPAN_W-1:0] top;
        logic [SPAN_W-1:0] bottom;
        logic [TEX_W-1:0]  color;
    } span_t;

endpackage

@@ rtl/core/vcso_sample_if.sv @@
// vcso_sample_if: valid/ready channel carrying one column sample or clear command
// depends on vcso_pkg
`timescale 1ns / 1ps

interface vcso_sample_if;
    import vcso_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [COL_W-1:0]   column;
    logic [TEX_W-1:0]   texel_height;
    logic [TEX_W-1:0]   texel_color;
    logic [SCALE_W-1:0] depth_scale;

    modport source
    (
        output valid, cmd, column, texel_height, texel_color, depth_scale,
        input  ready
    );

    modport sink
    (
        input  valid, cmd, column, texel_height, texel_color, depth_scale,
        output ready
    );

endinterface

@@ rtl/core/vcso_span_if.sv @@
// vcso_span_if: valid/ready channel carrying one span result
// depends on vcso_pkg
`timescale 1ns / 1ps

interface vcso_span_if;
    import vcso_pkg::*;

    logic              valid;
    logic              ready;
    logic              span_valid;
    logic [COL_W-1:0]  span_column;
    logic [SPAN_W-1:0] span_top;
    logic [SPAN_W-1:0] span_bottom;
    logic [TEX_W-1:0]  span_color;

    modport source
    (
        output valid, span_valid, span_column, span_top, span_bottom, span_color,
        input  ready
    );

    modport sink
    (
        input  valid, span_valid, span_column, span_top, span_bottom, span_color,
        output ready
    );

endinterface

@@ rtl/core/voxel_column_span_occlusion.sv @@
// voxel_column_span_occlusion: projects height texels to rows, keeps per-column
// top-filled row in an on-chip memory and emits the newly visible span
// depends on vcso_pkg, vcso_sample_if, vcso_span_if
// the sample passes the stage a and stage b registers before the result register holds its span
// throughput: one sample per cycle in run state without output stall, via row memory bypass
// a clear transfer blocks input until it leaves the memory stage, then a sweep over all
// SCREEN_WIDTH (320) column entries rewrites every one of them
// reset: async active low; starts the same sweep before the first transfer
`timescale 1ns / 1ps

module voxel_column_span_occlusion
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [vcso_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vcso_pkg::CFG_W-1:0]     cfg_data,
    vcso_sample_if.sink                    sample,
    vcso_span_if.source                    span
);
    import vcso_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SCREEN_WIDTH - 1);

    logic signed [CFG_W-1:0] cam_height_reg;
    logic signed [CFG_W-1:0] horizon_row_reg;

    occ_state_t              state_reg;
    occ_state_t              state_next;
    logic [ADDR_W-1:0]       sweep_idx_reg;
    logic                    accept_en;
    logic                    sweep_we;

    logic                    a_v_reg;
    cmd_t                    a_cmd_reg;
    logic [COL_W-1:0]        a_col_reg;
    logic [TEX_W-1:0]        a_h_reg;
    logic [TEX_W-1:0]        a_color_reg;
    logic [SCALE_W-1:0]      a_scale_reg;

    logic                    b_v_reg;
    cmd_t                    b_cmd_reg;
    logic                    b_in_range_reg;
    logic [COL_W-1:0]        b_col_reg;
    logic [TEX_W-1:0]        b_color_reg;
    logic signed [PROD_W-1:0] b_prod_reg;
    logic [ROW_W-1:0]        stored_reg;

    logic                    out_v_reg;
    span_t                   out_reg;
    span_t                   span_next;

    logic                    c_free;
    logic                    b_go;
    logic                    b_free;
    logic                    a_go;
    logic                    a_free;
    logic                    in_xfer;

    logic signed [DIFF_W-1:0] a_diff;
    logic signed [PROD_W-1:0] a_prod;
    logic                    a_in_range;
    logic [ADDR_W-1:0]       rd_addr;

    logic signed [ACC_W-1:0] b_acc;
    logic [ROW_W-1:0]        b_row;
    logic                    span_hit;
    logic                    smp_we;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_wa;
    logic [ROW_W-1:0]        mem_wd;
    logic [ROW_W-1:0]        filled_top [SCREEN_WIDTH];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_height_reg  <= CAM_HEIGHT_RESET;
            horizon_row_reg <= HORIZON_ROW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CAM_HEIGHT:  cam_height_reg  <= cfg_data;
                CFG_HORIZON_ROW: horizon_row_reg <= cfg_data;
                default:         cam_height_reg  <= cam_height_reg;
            endcase
        end
    end

    // handshake between stages
    assign c_free       = !out_v_reg || span.ready;
    assign b_go         = b_v_reg && c_free;
    assign b_free       = !b_v_reg || c_free;
    assign a_go         = a_v_reg && b_free;
    assign a_free       = !a_v_reg || b_free;
    assign sample.ready = a_free && accept_en;
    assign in_xfer      = sample.valid && sample.ready;

    // sweep / run / drain control
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_idx_reg == LAST_ADDR)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (in_xfer && (cmd_t'(sample.cmd) == CMD_CLEAR))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (b_go && (b_cmd_reg == CMD_CLEAR))
                begin
                    state_next = ST_SWEEP;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    always_comb
    begin
        accept_en = (state_reg == ST_RUN);
        sweep_we  = (state_reg == ST_SWEEP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (sweep_we)
            begin
                sweep_idx_reg <= (sweep_idx_reg == LAST_ADDR) ? '0 : sweep_idx_reg + 1'b1;
            end
        end
    end

    // stage a: input register, multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (a_free)
        begin
            a_v_reg <= in_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_cmd_reg   <= cmd_t'(sample.cmd);
            a_col_reg   <= sample.column;
            a_h_reg     <= sample.texel_height;
            a_color_reg <= sample.texel_color;
            a_scale_reg <= sample.depth_scale;
        end
    end

    always_comb
    begin
        a_diff = $signed({cam_height_reg[CFG_W-1], cam_height_reg})
               - $signed({{(DIFF_W - TEX_W - H_SHIFT){1'b0}}, a_h_reg, {H_SHIFT{1'b0}}});
        a_prod     = a_diff * $signed({1'b0, a_scale_reg});
        a_in_range = (int'(a_col_reg) < SCREEN_WIDTH);
        rd_addr    = a_in_range ? ADDR_W'(a_col_reg) : '0;
    end

    // stage b: row, occlusion test, memory update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (b_free)
        begin
            b_v_reg <= a_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_go)
        begin
            b_cmd_reg      <= a_cmd_reg;
            b_in_range_reg <= a_in_range;
            b_col_reg      <= a_col_reg;
            b_color_reg    <= a_color_reg;
            b_prod_reg     <= a_prod;
        end
    end

    always_comb
    begin
        b_acc = ACC_W'(b_prod_reg) + (ACC_W'(horizon_row_reg) <<< HOR_SHIFT);
        priority if (b_acc[ACC_W-1])
        begin
            b_row = '0;
        end
        else if (b_acc[ACC_W-2:ROW_LSB] > (ACC_W - 1 - ROW_LSB)'(SCREEN_HEIGHT))
        begin
            b_row = ROW_W'(SCREEN_HEIGHT);
        end
        else
        begin
            b_row = ROW_W'(b_acc[ACC_W-2:ROW_LSB]);
        end

        span_hit = (b_cmd_reg == CMD_SAMPLE) && b_in_range_reg && (b_row < stored_reg);
        smp_we   = b_go && span_hit;

        span_next = '0;
        if (span_hit)
        begin
            span_next.span_valid = 1'b1;
            span_next.column     = b_col_reg;
            span_next.top        = SPAN_W'(b_row);
            span_next.bottom     = SPAN_W'(stored_reg);
            span_next.color      = b_color_reg;
        end

        mem_we = sweep_we || smp_we;
        mem_wa = sweep_we ? sweep_idx_reg : ADDR_W'(b_col_reg);
        mem_wd = sweep_we ? ROW_W'(SCREEN_HEIGHT) : b_row;
    end

    // row memory, read with write bypass
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            filled_top[mem_wa] <= mem_wd;
        end
        if (a_go)
        begin
            stored_reg <= (mem_we && (mem_wa == rd_addr)) ? mem_wd : filled_top[rd_addr];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (c_free)
        begin
            out_v_reg <= b_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_go)
        begin
            out_reg <= span_next;
        end
    end

    assign span.valid       = out_v_reg;
    assign span.span_valid  = out_reg.span_valid;
    assign span.span_column = out_reg.column;
    assign span.span_top    = out_reg.top;
    assign span.span_bottom = out_reg.bottom;
    assign span.span_color  = out_reg.color;

    // no transfer while the store is being rewritten or a clear is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |-> !sample.ready)
        else $error("sample accepted outside run state");

    // the sweep owns the memory port only with the pipeline empty
    assert property (@(posedge clk) disable iff (!rst_n)
        sweep_we |-> (!a_v_reg && !b_v_reg))
        else $error("sweep overlaps pipelined samples");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (cmd_t'(sample.cmd) == CMD_CLEAR)) |=> (state_reg == ST_DRAIN))
        else $error("clear transfer did not block input");

    assert property (@(posedge clk) disable iff (!rst_n)
        (span.valid && span.span_valid) |->
            ((span.span_top < span.span_bottom) && (int'(span.span_bottom) <= SCREEN_HEIGHT)))
        else $error("span rows out of order or below screen");

endmodule
